FILE: sv/wsos_pkg.sv
package wsos_pkg;

   localparam logic [1:0] ACT_STEER    = 2'd0;
   localparam logic [1:0] ACT_STRAIGHT = 2'd1;
   localparam logic [1:0] ACT_RESTART  = 2'd2;

   localparam logic [2:0] REG_START_X   = 3'd0;
   localparam logic [2:0] REG_START_Y   = 3'd1;
   localparam logic [2:0] REG_START_HDG = 3'd2;
   localparam logic [2:0] REG_SPEED     = 3'd3;
   localparam logic [2:0] REG_RADIUS    = 3'd4;
   localparam logic [2:0] REG_TIME_STEP = 3'd5;

   // CORDIC operand sources
   localparam logic [2:0] SRC_HEAD  = 3'd0;
   localparam logic [2:0] SRC_HEADM = 3'd1;
   localparam logic [2:0] SRC_ANG   = 3'd2;
   localparam logic [2:0] SRC_GOAL  = 3'd3;
   localparam logic [2:0] SRC_ORB   = 3'd4;

   // datapath update operations
   localparam logic [2:0] OP_NONE    = 3'd0;
   localparam logic [2:0] OP_CENTER  = 3'd1;
   localparam logic [2:0] OP_ORBA    = 3'd2;
   localparam logic [2:0] OP_ORBPOS  = 3'd3;
   localparam logic [2:0] OP_STEERH  = 3'd4;
   localparam logic [2:0] OP_MOVE    = 3'd5;
   localparam logic [2:0] OP_RESTART = 3'd6;

   localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
   localparam logic [29:0] RAD_TO_ANG   = 30'd683565276;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam int          DIV_STEPS    = 46;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic       cor_start;
      logic [2:0] cor_src;
      logic [2:0] op;
      logic       capture;
   } cmd_type;

   typedef struct packed {
      logic       cor_done;
      logic       div_done;
      logic       near;
      logic       hold;
      logic [1:0] action;
   } sts_type;

   function automatic logic [31:0] ang_tab(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [33:0] v);
      logic [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [15:0] to_heading(input logic [31:0] a);
      logic [31:0] s;
      s = a + 32'h0000_8000;
      return s[31:16];
   endfunction

endpackage

FILE: sv/wsos_if.sv
interface wsos_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  action;
   logic signed [31:0] goal_x;
   logic signed [31:0] goal_y;
   modport source (output valid, action, goal_x, goal_y, input ready);
   modport sink   (input valid, action, goal_x, goal_y, output ready);
endinterface

interface wsos_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic        [15:0] heading;
   logic               orbiting;
   modport source (output valid, pos_x, pos_y, heading, orbiting, input ready);
   modport sink   (input valid, pos_x, pos_y, heading, orbiting, output ready);
endinterface

FILE: sv/wsos_ctrl.sv
module wsos_ctrl import wsos_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DISP = 4'd1;
   localparam logic [3:0] S_CEN  = 4'd2;
   localparam logic [3:0] S_ORB0 = 4'd3;
   localparam logic [3:0] S_ORB1 = 4'd4;
   localparam logic [3:0] S_ORB2 = 4'd5;
   localparam logic [3:0] S_ORB3 = 4'd6;
   localparam logic [3:0] S_STR  = 4'd7;
   localparam logic [3:0] S_MV0  = 4'd8;
   localparam logic [3:0] S_MOVE = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.cor_src  = SRC_HEAD;
      cmd.op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            cmd.div_start = 1'b1;
            case (sts.action)
               ACT_STEER: begin
                  cmd.cor_start = 1'b1;
                  if (sts.near && !sts.hold) begin
                     cmd.cor_src = SRC_HEADM;
                     state_in    = S_CEN;
                  end else if (sts.near) begin
                     cmd.cor_src = SRC_ORB;
                     state_in    = S_ORB1;
                  end else begin
                     cmd.cor_src = SRC_GOAL;
                     state_in    = S_STR;
                  end
               end
               ACT_STRAIGHT: begin
                  cmd.cor_start = 1'b1;
                  cmd.cor_src   = SRC_HEAD;
                  state_in      = S_MOVE;
               end
               ACT_RESTART: begin
                  cmd.op   = OP_RESTART;
                  state_in = S_OUT;
               end
               default: state_in = S_OUT;
            endcase
         end
         S_CEN: begin
            if (sts.cor_done) begin
               cmd.op   = OP_CENTER;
               state_in = S_ORB0;
            end
         end
         S_ORB0: begin
            cmd.cor_start = 1'b1;
            cmd.cor_src   = SRC_ORB;
            state_in      = S_ORB1;
         end
         S_ORB1: begin
            if (sts.cor_done && sts.div_done) begin
               cmd.op   = OP_ORBA;
               state_in = S_ORB2;
            end
         end
         S_ORB2: begin
            cmd.cor_start = 1'b1;
            cmd.cor_src   = SRC_ANG;
            state_in      = S_ORB3;
         end
         S_ORB3: begin
            if (sts.cor_done) begin
               cmd.op   = OP_ORBPOS;
               state_in = S_OUT;
            end
         end
         S_STR: begin
            if (sts.cor_done && sts.div_done) begin
               cmd.op   = OP_STEERH;
               state_in = S_MV0;
            end
         end
         S_MV0: begin
            cmd.cor_start = 1'b1;
            cmd.cor_src   = SRC_HEAD;
            state_in      = S_MOVE;
         end
         S_MOVE: begin
            if (sts.cor_done) begin
               cmd.op   = OP_MOVE;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.capture  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/wsos_dp.sv
module wsos_dp import wsos_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic        [2:0]  csr_index,
   input  logic        [31:0] csr_wdata,
   input  logic        [1:0]  in_action,
   input  logic signed [31:0] in_goal_x,
   input  logic signed [31:0] in_goal_y,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic signed [31:0] out_x,
   output logic signed [31:0] out_y,
   output logic        [15:0] out_heading,
   output logic               out_orbiting
);

   localparam int IW = $clog2(CORDIC_ITERATIONS);

   // configuration
   logic signed [31:0] sx_ff, sy_ff;
   logic        [15:0] sh_ff, spd_ff, rad_ff, ts_ff;
   logic        [31:0] num_ff;

   // vehicle state
   logic signed [31:0] cur_x_ff, cur_y_ff, ocx_ff, ocy_ff, gx_ff, gy_ff;
   logic        [15:0] cur_h_ff;
   logic               hold_ff;
   logic        [1:0]  act_ff;
   logic        [31:0] a_ff;

   // divider
   logic [45:0] dvd_ff;
   logic [15:0] rem_ff;
   logic [5:0]  dcnt_ff;
   logic        dbusy_ff;

   // cordic
   logic signed [35:0] vx_ff, vy_ff;
   logic signed [33:0] vz_ff;
   logic               rot_ff, flip_ff, zero_ff, cbusy_ff;
   logic [IW-1:0]      it_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff  <= '0;
         sy_ff  <= '0;
         sh_ff  <= '0;
         spd_ff <= 16'd256;
         rad_ff <= 16'd256;
         ts_ff  <= 16'd4096;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_START_X:   sx_ff  <= csr_wdata;
            REG_START_Y:   sy_ff  <= csr_wdata;
            REG_START_HDG: sh_ff  <= csr_wdata[15:0];
            REG_SPEED:     spd_ff <= csr_wdata[15:0];
            REG_RADIUS:    rad_ff <= csr_wdata[15:0];
            REG_TIME_STEP: ts_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= spd_ff * ts_ff;
   end

   logic [15:0] r_eff;
   logic [23:0] rq, len;
   assign r_eff = (rad_ff == 16'd0) ? 16'd1 : rad_ff;
   assign rq    = {r_eff, 8'h00};
   assign len   = num_ff[31:8];

   // divider: floor(num*K / 2^16) / r, one quotient bit per cycle
   logic [61:0] dprod;
   logic [16:0] rsh;
   logic        dge;
   assign dprod = 62'(num_ff) * 62'(RAD_TO_ANG);
   assign rsh   = {rem_ff, dvd_ff[45]};
   assign dge   = rsh >= {1'b0, r_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         dcnt_ff  <= '0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
         dcnt_ff  <= '0;
      end else if (dbusy_ff) begin
         dcnt_ff <= dcnt_ff + 6'd1;
         if (dcnt_ff == 6'(DIV_STEPS - 1)) begin
            dbusy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff <= dprod[61:16];
         rem_ff <= '0;
      end else if (dbusy_ff) begin
         rem_ff <= dge ? 16'(rsh - {1'b0, r_eff}) : rsh[15:0];
         dvd_ff <= {dvd_ff[44:0], dge};
      end
   end

   // cordic operand setup
   logic        [31:0] h32, ang, ang_q, ang2;
   logic               fl;
   logic signed [32:0] ex, ey;
   logic signed [35:0] ex36, ey36;
   logic               rot_src;

   assign h32 = {cur_h_ff, 16'h0000};

   always_comb begin
      ang     = h32;
      ex      = 33'(gx_ff) - 33'(cur_x_ff);
      ey      = 33'(gy_ff) - 33'(cur_y_ff);
      rot_src = 1'b1;
      case (cmd.cor_src)
         SRC_HEADM: ang = h32 - QUARTER_TURN;
         SRC_ANG:   ang = a_ff;
         SRC_GOAL:  rot_src = 1'b0;
         SRC_ORB: begin
            rot_src = 1'b0;
            ex      = 33'(cur_x_ff) - 33'(ocx_ff);
            ey      = 33'(cur_y_ff) - 33'(ocy_ff);
         end
         default: ang = h32;
      endcase
   end

   assign ang_q = ang + QUARTER_TURN;
   assign fl    = ang_q[31];
   assign ang2  = fl ? (ang + 32'h8000_0000) : ang;
   assign ex36  = 36'(ex);
   assign ey36  = 36'(ey);

   // cordic iteration
   logic signed [35:0] xsh, ysh;
   logic signed [33:0] tab;
   logic               pos;
   assign xsh = vx_ff >>> it_ff;
   assign ysh = vy_ff >>> it_ff;
   assign tab = $signed({2'b00, ang_tab(5'(it_ff))});
   assign pos = rot_ff ? !vz_ff[33] : (vy_ff <= 36'sd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cbusy_ff <= 1'b0;
         it_ff    <= '0;
      end else if (cmd.cor_start) begin
         cbusy_ff <= 1'b1;
         it_ff    <= '0;
      end else if (cbusy_ff) begin
         it_ff <= it_ff + 1'b1;
         if (it_ff == IW'(CORDIC_ITERATIONS - 1)) begin
            cbusy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cor_start) begin
         rot_ff <= rot_src;
         if (rot_src) begin
            vx_ff   <= 36'(INV_GAIN_Q30);
            vy_ff   <= '0;
            vz_ff   <= 34'($signed(ang2));
            flip_ff <= fl;
            zero_ff <= 1'b0;
         end else begin
            vx_ff   <= ex[32] ? -ex36 : ex36;
            vy_ff   <= ex[32] ? -ey36 : ey36;
            vz_ff   <= ex[32] ? 34'sh0_8000_0000 : 34'sd0;
            flip_ff <= 1'b0;
            zero_ff <= (ex == 33'sd0) && (ey == 33'sd0);
         end
      end else if (cbusy_ff) begin
         if (pos) begin
            vx_ff <= vx_ff - ysh;
            vy_ff <= vy_ff + xsh;
            vz_ff <= vz_ff - tab;
         end else begin
            vx_ff <= vx_ff + ysh;
            vy_ff <= vy_ff - xsh;
            vz_ff <= vz_ff + tab;
         end
      end
   end

   // results and updates
   logic signed [35:0] rc, rs;
   logic        [31:0] zang;
   logic        [23:0] fac;
   logic signed [60:0] px, py;
   logic signed [31:0] bx, by;
   logic        [31:0] nx, ny;

   assign rc   = flip_ff ? -vx_ff : vx_ff;
   assign rs   = flip_ff ? -vy_ff : vy_ff;
   assign zang = zero_ff ? 32'h0 : vz_ff[31:0];
   assign fac  = (cmd.op == OP_MOVE) ? len : rq;
   assign px   = $signed({1'b0, fac}) * rc;
   assign py   = $signed({1'b0, fac}) * rs;

   always_comb begin
      case (cmd.op)
         OP_CENTER: begin
            bx = gx_ff;
            by = gy_ff;
         end
         OP_ORBPOS: begin
            bx = ocx_ff;
            by = ocy_ff;
         end
         default: begin
            bx = cur_x_ff;
            by = cur_y_ff;
         end
      endcase
   end

   assign nx = sat32(34'(bx) + 34'($signed(px[60:30])));
   assign ny = sat32(34'(by) + 34'($signed(py[60:30])));

   // steering clamp
   logic [31:0]        err32, newh32;
   logic [32:0]        lim;
   logic signed [33:0] e34, l34, ec;
   assign err32  = zang - h32;
   assign lim    = (dvd_ff > 46'd2147483648) ? 33'h0_8000_0000 : dvd_ff[32:0];
   assign e34    = 34'($signed(err32));
   assign l34    = $signed({1'b0, lim});
   assign ec     = (e34 > l34) ? l34 : ((e34 < -l34) ? -l34 : e34);
   assign newh32 = h32 + ec[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         cur_h_ff <= '0;
         hold_ff  <= 1'b0;
         ocx_ff   <= '0;
         ocy_ff   <= '0;
      end else begin
         case (cmd.op)
            OP_CENTER: begin
               ocx_ff  <= nx;
               ocy_ff  <= ny;
               hold_ff <= 1'b1;
            end
            OP_ORBPOS: begin
               cur_x_ff <= nx;
               cur_y_ff <= ny;
               cur_h_ff <= to_heading(a_ff - QUARTER_TURN);
            end
            OP_STEERH: cur_h_ff <= to_heading(newh32);
            OP_MOVE: begin
               cur_x_ff <= nx;
               cur_y_ff <= ny;
            end
            OP_RESTART: begin
               cur_x_ff <= sx_ff;
               cur_y_ff <= sy_ff;
               cur_h_ff <= sh_ff;
               hold_ff  <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ORBA) begin
         a_ff <= zang - dvd_ff[31:0];
      end
      if (cmd.load) begin
         gx_ff  <= in_goal_x;
         gy_ff  <= in_goal_y;
         act_ff <= in_action;
      end
      if (cmd.capture) begin
         out_x        <= cur_x_ff;
         out_y        <= cur_y_ff;
         out_heading  <= cur_h_ff;
         out_orbiting <= hold_ff;
      end
   end

   // 1 m proximity test
   logic signed [32:0] gdx, gdy;
   logic signed [13:0] sdx, sdy;
   logic        [27:0] dsq;
   logic               inbox;
   assign gdx   = 33'(gx_ff) - 33'(cur_x_ff);
   assign gdy   = 33'(gy_ff) - 33'(cur_y_ff);
   assign inbox = (gdx >= -33'sd4096) && (gdx <= 33'sd4096) &&
                  (gdy >= -33'sd4096) && (gdy <= 33'sd4096);
   assign sdx   = gdx[13:0];
   assign sdy   = gdy[13:0];
   assign dsq   = 28'(sdx * sdx) + 28'(sdy * sdy);

   assign sts.cor_done = !cbusy_ff;
   assign sts.div_done = !dbusy_ff;
   assign sts.near     = inbox && (dsq <= 28'd16777216);
   assign sts.hold     = hold_ff;
   assign sts.action   = act_ff;

endmodule

FILE: sv/waypoint_steer_and_orbit_step.sv
// Steps: a restart or unused action goes from dispatch straight to output;
// move straight waits only on a CORDIC pass; steering and orbit steps also
// wait on the turn-rate divider, which runs beside their CORDIC passes.
// One step at a time: input is ready again as the result turns valid, and a
// stalled result holds the next step in its output state.
// Synchronous active-high reset loads the default registers and start pose.
module waypoint_steer_and_orbit_step import wsos_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   wsos_req_if.sink    req_if,
   wsos_rsp_if.source  rsp_if,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   wsos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wsos_dp #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_action    (req_if.action),
      .in_goal_x    (req_if.goal_x),
      .in_goal_y    (req_if.goal_y),
      .cmd          (cmd),
      .sts          (sts),
      .out_x        (rsp_if.pos_x),
      .out_y        (rsp_if.pos_y),
      .out_heading  (rsp_if.heading),
      .out_orbiting (rsp_if.orbiting)
   );

endmodule
